@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define IPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define IPT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/ipt_pkg.sv @@
// ----------------------------------------------------------------------------
// ipt_pkg
// Types and constants shared by the address-to-text formatter and serialiser.
// ----------------------------------------------------------------------------
package ipt_pkg;

    // Configuration port geometry and register map.
    localparam int ADDR_W = 3;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic REG_OUT_LIMIT = 1'b0;

    // Address family codes.
    localparam logic [1:0] CMD_IPV4 = 2'd0;
    localparam logic [1:0] CMD_IPV6 = 2'd1;

    // ASCII characters used in the text.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_HEX_A = 8'h57;

    // The text is cut into eight fields of up to eight characters each.
    localparam int NUM_FIELDS = 8;
    localparam int FIELD_CHARS = 8;

    typedef logic [7:0] char_t;
    typedef char_t [FIELD_CHARS-1:0] fchars_t;
    typedef logic [3:0] flen_t;
    typedef logic [2:0] fidx_t;

    typedef struct packed {
        fchars_t ch;
        flen_t   len;
    } field_t;

    // One formatted request handed to the serialiser.
    typedef struct packed {
        field_t [NUM_FIELDS-1:0] fld;
        fidx_t [NUM_FIELDS-1:0]  nxt;
        logic [NUM_FIELDS-1:0]   has_nxt;
        logic                    err;
    } text_t;

endpackage

@@ hdl/ipt_fmt.sv @@
// ----------------------------------------------------------------------------
// ipt_fmt
// Five-stage pipeline that turns an address request into text fields.
// ----------------------------------------------------------------------------
module ipt_fmt import ipt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_cmd,
    input  logic [63:0]        in_high,
    input  logic [63:0]        in_low,
    input  logic [LIMIT_W-1:0] out_limit,
    output logic               out_valid,
    input  logic               out_ready,
    output text_t              out_item
);

    typedef struct packed {
        logic [3:0][7:0] ch;
        logic [2:0]      n;
    } hexw_t;

    typedef struct packed {
        logic [2:0][7:0] ch;
        logic [1:0]      n;
    } decb_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] base;
        logic [3:0] len;
    } run_t;

    // ASCII for one hex digit, lower case.
    function automatic char_t hex_char(logic [3:0] d);
        if (d < 4'd10) begin
            return CH_ZERO + {4'b0, d};
        end
        return CH_HEX_A + {4'b0, d};
    endfunction

    // Hex word without leading zeros, characters left aligned.
    function automatic hexw_t hex_word(logic [15:0] w);
        hexw_t      r;
        logic [2:0] start;
        logic [2:0] k;
        logic [15:0] sh;
        r.ch = '0;
        if (w[15:12] != 4'd0) begin
            r.n = 3'd4;
        end else if (w[11:8] != 4'd0) begin
            r.n = 3'd3;
        end else if (w[7:4] != 4'd0) begin
            r.n = 3'd2;
        end else begin
            r.n = 3'd1;
        end
        start = 3'd4 - r.n;
        for (int j = 0; j < 4; j++) begin
            k = start + 3'(j);
            sh = w << {k[1:0], 2'b00};
            if (3'(j) < r.n) begin
                r.ch[j] = hex_char(sh[15:12]);
            end
        end
        return r;
    endfunction

    // Decimal byte without leading zeros; tens found by a reciprocal multiply.
    function automatic decb_t dec_byte(logic [7:0] v);
        decb_t       r;
        logic [1:0]  h;
        logic [7:0]  rem;
        logic [15:0] prod;
        logic [3:0]  t;
        logic [7:0]  u;
        if (v >= 8'd200) begin
            h = 2'd2;
            rem = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 2'd1;
            rem = v - 8'd100;
        end else begin
            h = 2'd0;
            rem = v;
        end
        prod = {8'b0, rem} * 16'd205;
        t = prod[14:11];
        u = rem - {1'b0, t, 3'b000} - {3'b000, t, 1'b0};
        r.ch = '0;
        if (v >= 8'd100) begin
            r.n = 2'd3;
            r.ch[0] = CH_ZERO + {6'b0, h};
            r.ch[1] = CH_ZERO + {4'b0, t};
            r.ch[2] = CH_ZERO + u;
        end else if (v >= 8'd10) begin
            r.n = 2'd2;
            r.ch[0] = CH_ZERO + {4'b0, t};
            r.ch[1] = CH_ZERO + u;
        end else begin
            r.n = 2'd1;
            r.ch[0] = CH_ZERO + u;
        end
        return r;
    endfunction

    // First longest run of zero words, dropped when shorter than two.
    function automatic run_t zero_run(logic [7:0] z);
        run_t       best;
        logic       cur_v;
        logic [2:0] cur_b;
        logic [3:0] cur_l;
        best = '0;
        cur_v = 1'b0;
        cur_b = 3'd0;
        cur_l = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (z[i]) begin
                if (!cur_v) begin
                    cur_v = 1'b1;
                    cur_b = 3'(i);
                    cur_l = 4'd1;
                end else begin
                    cur_l = cur_l + 4'd1;
                end
            end else if (cur_v) begin
                if (!best.valid || cur_l > best.len) begin
                    best.valid = 1'b1;
                    best.base = cur_b;
                    best.len = cur_l;
                end
                cur_v = 1'b0;
            end
        end
        if (cur_v && (!best.valid || cur_l > best.len)) begin
            best.valid = 1'b1;
            best.base = cur_b;
            best.len = cur_l;
        end
        if (best.valid && best.len < 4'd2) begin
            best.valid = 1'b0;
        end
        return best;
    endfunction

    function automatic fchars_t one_char(char_t c);
        fchars_t p;
        p = '0;
        p[0] = c;
        return p;
    endfunction

    function automatic fchars_t hex_part(hexw_t h);
        fchars_t p;
        p = '0;
        for (int j = 0; j < 4; j++) begin
            p[j] = h.ch[j];
        end
        return p;
    endfunction

    function automatic fchars_t dec_part(decb_t d);
        fchars_t p;
        p = '0;
        for (int j = 0; j < 3; j++) begin
            p[j] = d.ch[j];
        end
        return p;
    endfunction

    // Appends a part of plen characters to a field.
    function automatic field_t fld_append(field_t f, fchars_t p, flen_t plen);
        field_t r;
        flen_t  k;
        r.ch = '0;
        r.len = f.len + plen;
        for (int j = 0; j < FIELD_CHARS; j++) begin
            k = flen_t'(j) - f.len;
            if (flen_t'(j) < f.len) begin
                r.ch[j] = f.ch[j];
            end else if (k < plen) begin
                r.ch[j] = p[k[2:0]];
            end
        end
        return r;
    endfunction

    // Stage registers.
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [1:0]  cmd1_reg, cmd2_reg, cmd3_reg;
    logic        err4_reg;
    logic [63:0] hi1_reg, lo1_reg;
    logic [7:0]  zero2_reg;
    logic        ffff2_reg;
    hexw_t [7:0] hex2_reg, hex3_reg;
    decb_t [3:0] dec2_reg, dec3_reg;
    logic [7:0]  inrun3_reg;
    logic [2:0]  base3_reg;
    logic        mapped3_reg;
    field_t [7:0] fld4_reg;
    text_t       item5_reg;

    logic adv1, adv2, adv3, adv4, adv5;

    // Each stage moves when it is empty or the stage after it moves.
    assign adv5 = !v5_reg || out_ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v5_reg;
    assign out_item = item5_reg;

    // Stage two: words, zero flags, hex and decimal digits.
    logic [15:0] word [8];
    logic [7:0]  zero2_next;
    hexw_t [7:0] hex2_next;
    decb_t [3:0] dec2_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            word[i] = hi1_reg[63-16*i -: 16];
            word[i+4] = lo1_reg[63-16*i -: 16];
        end
        for (int i = 0; i < 8; i++) begin
            zero2_next[i] = (word[i] == 16'd0);
            hex2_next[i] = hex_word(word[i]);
        end
        for (int k = 0; k < 4; k++) begin
            dec2_next[k] = dec_byte(lo1_reg[31-8*k -: 8]);
        end
    end

    // Stage three: zero-run search and the embedded IPv4 case.
    run_t       run3;
    logic [7:0] inrun3_next;
    logic       mapped3_next;

    always_comb begin
        run3 = zero_run(zero2_reg);
        for (int i = 0; i < 8; i++) begin
            inrun3_next[i] = run3.valid && (4'(i) >= {1'b0, run3.base})
                && (4'(i) < ({1'b0, run3.base} + run3.len));
        end
        mapped3_next = run3.valid && (run3.base == 3'd0)
            && ((run3.len == 4'd6) || ((run3.len == 4'd5) && ffff2_reg));
    end

    // Stage four: each field's characters.
    field_t [7:0] fld4_next;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            fld4_next[i] = '0;
            if (cmd3_reg == CMD_IPV4) begin
                if (i < 4) begin
                    if (i != 0) begin
                        fld4_next[i] = fld_append(fld4_next[i], one_char(CH_DOT), 4'd1);
                    end
                    fld4_next[i] = fld_append(fld4_next[i], dec_part(dec3_reg[i]),
                        {2'b0, dec3_reg[i].n});
                end
            end else if (inrun3_reg[i]) begin
                if (base3_reg == 3'(i)) begin
                    fld4_next[i] = fld_append(fld4_next[i], one_char(CH_COLON), 4'd1);
                end
                if (i == 7) begin
                    fld4_next[i] = fld_append(fld4_next[i], one_char(CH_COLON), 4'd1);
                end
            end else if (mapped3_reg && (i >= 6)) begin
                fld4_next[i] = fld_append(fld4_next[i],
                    one_char((i == 6) ? CH_COLON : CH_DOT), 4'd1);
                fld4_next[i] = fld_append(fld4_next[i], dec_part(dec3_reg[2*(i-6)]),
                    {2'b0, dec3_reg[2*(i-6)].n});
                fld4_next[i] = fld_append(fld4_next[i], one_char(CH_DOT), 4'd1);
                fld4_next[i] = fld_append(fld4_next[i], dec_part(dec3_reg[2*(i-6)+1]),
                    {2'b0, dec3_reg[2*(i-6)+1].n});
            end else begin
                if (i != 0) begin
                    fld4_next[i] = fld_append(fld4_next[i], one_char(CH_COLON), 4'd1);
                end
                fld4_next[i] = fld_append(fld4_next[i], hex_part(hex3_reg[i]),
                    {1'b0, hex3_reg[i].n});
            end
        end
    end

    // Stage five: total length, limit check and links between fields.
    logic [6:0] total5;
    text_t      item5_next;

    always_comb begin
        total5 = 7'd0;
        for (int i = 0; i < 8; i++) begin
            total5 = total5 + {3'b0, fld4_reg[i].len};
        end
        item5_next.fld = fld4_reg;
        item5_next.err = err4_reg || ((total5 + 7'd1) > out_limit);
        for (int f = 0; f < 8; f++) begin
            item5_next.has_nxt[f] = 1'b0;
            item5_next.nxt[f] = 3'd0;
            for (int g = 7; g >= 0; g--) begin
                if ((g > f) && (fld4_reg[g].len != 4'd0)) begin
                    item5_next.has_nxt[f] = 1'b1;
                    item5_next.nxt[f] = 3'(g);
                end
            end
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (adv1) begin
            cmd1_reg <= in_cmd;
            hi1_reg <= in_high;
            lo1_reg <= in_low;
        end
        if (adv2) begin
            cmd2_reg <= cmd1_reg;
            zero2_reg <= zero2_next;
            ffff2_reg <= (word[5] == 16'hFFFF);
            hex2_reg <= hex2_next;
            dec2_reg <= dec2_next;
        end
        if (adv3) begin
            cmd3_reg <= cmd2_reg;
            inrun3_reg <= inrun3_next;
            base3_reg <= run3.base;
            mapped3_reg <= mapped3_next;
            hex3_reg <= hex2_reg;
            dec3_reg <= dec2_reg;
        end
        if (adv4) begin
            err4_reg <= (cmd3_reg != CMD_IPV4) && (cmd3_reg != CMD_IPV6);
            fld4_reg <= fld4_next;
        end
        if (adv5) begin
            item5_reg <= item5_next;
        end
    end

endmodule

@@ hdl/ipt_ser.sv @@
// ----------------------------------------------------------------------------
// ipt_ser
// Walks a request's fields, one character a cycle while m_tready is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipt_ser import ipt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  text_t in_item,
    output logic  m_tvalid,
    input  logic  m_tready,
    output logic [7:0] m_tdata,
    output logic  m_tlast,
    output logic  m_tuser
);

    logic   valid_reg;
    text_t  item_reg;
    fidx_t  f_reg;
    logic [2:0] c_reg;

    field_t cur;
    logic   ch_end;
    logic   is_last;

    // Current character and end-of-field detection.
    assign cur = item_reg.fld[f_reg];
    assign ch_end = (({1'b0, c_reg} + 4'd1) == cur.len);
    assign is_last = item_reg.err || (ch_end && !item_reg.has_nxt[f_reg]);

    assign m_tvalid = valid_reg;
    assign m_tdata = item_reg.err ? CH_NUL : cur.ch[c_reg];
    assign m_tlast = is_last;
    assign m_tuser = item_reg.err;

    // A new request is taken as the last character of the current one leaves.
    assign in_ready = !valid_reg || (m_tready && is_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            f_reg <= '0;
            c_reg <= '0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
            f_reg <= '0;
            c_reg <= '0;
        end else if (m_tready) begin
            if (ch_end) begin
                f_reg <= item_reg.nxt[f_reg];
                c_reg <= '0;
            end else begin
                c_reg <= c_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    `IPT_ASSERT(a_err_single, (valid_reg && item_reg.err) |-> (is_last && (m_tdata == CH_NUL)), "error result must be a single null character")
    `IPT_ASSERT(a_char_in_field, (valid_reg && !item_reg.err) |-> ({1'b0, c_reg} < cur.len), "character index beyond its field")
    `IPT_ASSERT(a_text_nonnull, (valid_reg && !item_reg.err) |-> (m_tdata != CH_NUL), "text character must not be null")
    `IPT_ASSERT_NEXT(a_text_continues, valid_reg && m_tready && !is_last, valid_reg, "text ended before its last character")

endmodule

@@ hdl/ip_address_to_text.sv @@
// ----------------------------------------------------------------------------
// ip_address_to_text: IPv4 and IPv6 addresses to ASCII text
// The formatter stages and then the serialiser register lie between a request
// and its first character. Throughput: one character per cycle while m_tready
// is high; a request's text is 2 to 39 characters, or one null for an error.
// Reset clears all valid bits and serialiser indices, sets out_limit to 64.
// ----------------------------------------------------------------------------
module ip_address_to_text import ipt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // Request channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [127:0]      s_tdata,   // [63:0] addr_high, [127:64] addr_low
    input  logic [1:0]        s_tuser,   // [1:0] cmd
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_char
    output logic              m_tlast,
    output logic              m_tuser,   // [0] error
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [LIMIT_W-1:0] out_limit_reg;
    logic               txt_valid;
    logic               txt_ready;
    text_t              txt_item;

    // Configuration register write and read-back.
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_OUT_LIMIT)
        ? {{(32-LIMIT_W){1'b0}}, out_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[ADDR_W-1:2] == REG_OUT_LIMIT)) begin
            out_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Formatting pipeline.
    ipt_fmt u_fmt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_high   (s_tdata[63:0]),
        .in_low    (s_tdata[127:64]),
        .out_limit (out_limit_reg),
        .out_valid (txt_valid),
        .out_ready (txt_ready),
        .out_item  (txt_item)
    );

    // Character serialiser.
    ipt_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (txt_valid),
        .in_ready (txt_ready),
        .in_item  (txt_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
